// ===== src/wcm_pkg.sv =====
// ---------------------------------------------------------------------------
// wcm_pkg
// Types and constants shared by the wall column texture mapper modules.
// ---------------------------------------------------------------------------
package wcm_pkg;

   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [2:0] FACE_NORTH = 3'd1;
   localparam logic [2:0] FACE_WEST  = 3'd4;

   typedef struct packed {
      logic        command;
      logic [9:0]  column;
      logic [15:0] wall_height;
      logic [8:0]  span_bottom;
      logic [8:0]  span_top;
      logic [2:0]  face;
      logic [5:0]  texel_column;
   } req_type;

   typedef struct packed {
      logic [18:0] frame_address;
      logic [1:0]  texture_face;
      logic [11:0] texture_offset;
      logic        last_in_column;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  column;
      logic [8:0]  row;
      logic [8:0]  end_row;
      logic [31:0] position;
      logic [31:0] step;
      logic [1:0]  face;
      logic [5:0]  texcol;
   } col_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

endpackage

// ===== src/wcm_divider.sv =====
// ---------------------------------------------------------------------------
// wcm_divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. done pulses for one cycle when the quotient is valid.
// ---------------------------------------------------------------------------
module wcm_divider
   import wcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] rem_shift;
   logic [16:0] diff;
   logic        ge;

   assign rem_shift = {rem_ff, dvd_ff[31]};
   assign diff      = rem_shift - {1'b0, dsr_ff};
   assign ge        = rem_shift >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[30:0], ge};
         rem_in = ge ? diff[15:0] : rem_shift[15:0];
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== src/wcm_pixel_gen.sv =====
// ---------------------------------------------------------------------------
// wcm_pixel_gen
// Per-pixel datapath: frame address, texture offset, last-row flag and the
// saturating advance of the texture position.
// ---------------------------------------------------------------------------
module wcm_pixel_gen
   import wcm_pkg::*;
#(
   parameter int SCREEN_WIDTH = 640,
   parameter int TEX_SIZE     = 64
) (
   input  col_type     col,
   output rsp_type     pix,
   output logic [31:0] next_position
);

   localparam logic [15:0] TexMax   = 16'(TEX_SIZE - 1);
   localparam logic [21:0] ScreenW  = 22'(SCREEN_WIDTH);
   localparam logic [16:0] TexSize  = 17'(TEX_SIZE);

   logic [15:0] trow_raw;
   logic [7:0]  trow;
   logic [21:0] addr_full;
   logic [16:0] off_full;
   logic [32:0] pos_sum;

   always_comb begin
      trow_raw  = col.position[31:16];
      trow      = (trow_raw > TexMax) ? TexMax[7:0] : trow_raw[7:0];
      addr_full = 22'(col.row) * ScreenW + 22'(col.column);
      off_full  = TexSize * 17'(trow) + 17'(col.texcol);
      pos_sum   = {1'b0, col.position} + {1'b0, col.step};

      pix.frame_address  = addr_full[18:0];
      pix.texture_face   = col.face;
      pix.texture_offset = off_full[11:0];
      pix.last_in_column = (col.row + 9'd1) == col.end_row;

      next_position = pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
   end

endmodule

// ===== src/wall_column_texture_mapper.sv =====
// ---------------------------------------------------------------------------
// wall_column_texture_mapper
// Texture mapping for one screen column of a wall: a begin transaction sets
// up step and start position, each pixel transaction for an active column yields one address pair.
//
//   channel  ports                          direction  transaction
//   req      req_valid req_stall req_data   in         begin or pixel
//   rsp      rsp_valid rsp_stall rsp_data   out        one pixel
//
// Pixel transactions: one per cycle unless a result waits on rsp_stall; the result is registered.
// Begin transactions: req stays stalled while the restoring divider runs (ST_DIVIDE),
// then through a multiply step (ST_MULTIPLY) and a saturate step (ST_FINISH).
// Invalid begins (zero height, empty span, bad face) start no divide and leave no column active.
// reset is synchronous; req_stall also holds while a result waits on rsp_stall.
// ---------------------------------------------------------------------------
module wall_column_texture_mapper
   import wcm_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480,
   parameter int TEX_SIZE      = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [31:0] TexOne  = 32'(TEX_SIZE) << 16;
   localparam logic [17:0] ScreenH = 18'(SCREEN_HEIGHT);
   localparam logic [7:0]  TexMax  = 8'(TEX_SIZE - 1);

   state_type   state_ff, state_in;
   logic        active_ff, active_in;
   col_type     col_ff, col_in;
   logic [16:0] n_ff, n_in;
   logic [48:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        begin_ok;
   logic        div_start;
   logic        div_done;
   logic        pixel_fire;
   logic        begin_fire;
   logic [31:0] quotient;
   rsp_type     pix;
   logic [31:0] next_position;
   logic [17:0] n_sum;
   logic [17:0] n_diff;
   logic [7:0]  tc_wide;
   logic [2:0]  face_m1;

   wcm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (TexOne),
      .divisor  (req_data.wall_height),
      .done     (div_done),
      .quotient (quotient)
   );

   wcm_pixel_gen #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .TEX_SIZE     (TEX_SIZE)
   ) u_pixel_gen (
      .col           (col_ff),
      .pix           (pix),
      .next_position (next_position)
   );

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign begin_ok  = (req_data.wall_height != 16'd0)
                   && (req_data.span_bottom < req_data.span_top)
                   && (req_data.face >= FACE_NORTH)
                   && (req_data.face <= FACE_WEST);
   assign n_sum     = 18'({req_data.span_bottom, 1'b0}) + 18'(req_data.wall_height);
   assign n_diff    = n_sum - ScreenH;
   assign tc_wide   = {2'b00, req_data.texel_column};
   assign face_m1   = req_data.face - 3'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (div_start) state_in = ST_DIVIDE;
         ST_DIVIDE:   if (div_done) state_in = ST_MULTIPLY;
         ST_MULTIPLY: state_in = ST_FINISH;
         ST_FINISH:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      begin_fire = 1'b0;
      pixel_fire = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            begin_fire = req_fire && (req_data.command == CMD_BEGIN);
            pixel_fire = req_fire && (req_data.command == CMD_PIXEL) && active_ff;
            div_start  = begin_fire && begin_ok;
         end
         default: begin
            begin_fire = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      active_in    = active_ff;
      col_in       = col_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (begin_fire) begin
         active_in = 1'b0;
      end
      if (div_start) begin
         col_in.column  = req_data.column;
         col_in.row     = req_data.span_bottom;
         col_in.end_row = req_data.span_top;
         col_in.face    = face_m1[1:0];
         col_in.texcol  = (tc_wide > TexMax) ? TexMax[5:0] : req_data.texel_column;
         n_in           = (n_sum > ScreenH) ? n_diff[16:0] : 17'd0;
      end
      if (pixel_fire) begin
         rsp_valid_in    = 1'b1;
         rsp_data_in     = pix;
         col_in.row      = col_ff.row + 9'd1;
         col_in.position = next_position;
         if (pix.last_in_column) begin
            active_in = 1'b0;
         end
      end
      if (state_ff == ST_MULTIPLY) begin
         col_in.step = quotient;
         prod_in     = 49'(n_ff) * 49'(quotient);
      end
      if (state_ff == ST_FINISH) begin
         col_in.position = (prod_ff[48:33] != 16'd0) ? 32'hFFFF_FFFF : prod_ff[32:1];
         active_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff      <= col_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_active: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(active_ff))
      else $error("pixel transaction issued without an active column");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("req taken during column setup");

   a_finish_activates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> active_ff)
      else $error("column not active after setup");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

endmodule

// ===== test/wall_column_texture_mapper_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// wall_column_texture_mapper_test
// Self-checking bench for the wall column texture mapper. A directed table
// covers reset, field extremes, rejected begins and column replacement. A
// long random run of column setups and pixel streams follows, with random
// idle cycles on both channels, a quiet stretch and one long receiver
// hold-off. Each pixel result is checked against an in-bench model or a pinned value.
// ---------------------------------------------------------------------------
module wall_column_texture_mapper_test;
   import wcm_pkg::*;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;
   localparam int TEX_SIZE      = 64;
   localparam int ITEM_TARGET   = 700;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 150;

   typedef struct packed {
      req_type item;
      bit      on;
      rsp_type known;
   } plan_row_type;

   typedef struct packed {
      bit      on;
      rsp_type known;
   } pin_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   col_type       col_state = '0;
   bit            column_live = 1'b0;
   rsp_type       texel_q[$];
   pin_entry_type pin_q[$];
   plan_row_type  plan[$];

   int  mismatches = 0;
   int  begins_seen = 0;
   int  pixels_checked = 0;
   int  work_done = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_left = 0;

   wall_column_texture_mapper DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, texel_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // column setup: step and start position in Q16.16
   function automatic void load_column(req_type t);
      longint     half_rows;
      logic [63:0] start;
      column_live = 1'b0;
      if (t.wall_height == 0 || t.span_bottom >= t.span_top ||
          t.face < FACE_NORTH || t.face > FACE_WEST)
         return;
      col_state.column  = t.column;
      col_state.row     = t.span_bottom;
      col_state.end_row = t.span_top;
      col_state.face    = 2'(t.face - 1);
      col_state.texcol  = (int'(t.texel_column) > TEX_SIZE - 1) ? 6'(TEX_SIZE - 1)
                                                                : t.texel_column;
      col_state.step    = 32'((64'(TEX_SIZE) << 16) / 64'(t.wall_height));
      half_rows = 2 * longint'(t.span_bottom) + longint'(t.wall_height) - SCREEN_HEIGHT;
      if (half_rows <= 0) begin
         start = '0;
      end else begin
         start = (64'(half_rows) * 64'(col_state.step)) >> 1;
         if (start > 64'hFFFF_FFFF)
            start = 64'hFFFF_FFFF;
      end
      col_state.position = start[31:0];
      column_live = 1'b1;
   endfunction

   function automatic bit next_pixel(output rsp_type r);
      int unsigned trow;
      logic [32:0] sum;
      bit          last;
      r = '0;
      if (!column_live)
         return 1'b0;
      trow = col_state.position[31:16];
      if (trow > TEX_SIZE - 1)
         trow = TEX_SIZE - 1;
      last = (int'(col_state.row) + 1 == int'(col_state.end_row));
      r.frame_address  = 19'(int'(col_state.row) * SCREEN_WIDTH + int'(col_state.column));
      r.texture_face   = col_state.face;
      r.texture_offset = 12'(TEX_SIZE * trow + col_state.texcol);
      r.last_in_column = last;
      sum = {1'b0, col_state.position} + {1'b0, col_state.step};
      col_state.position = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      col_state.row = col_state.row + 9'd1;
      if (last)
         column_live = 1'b0;
      return 1'b1;
   endfunction

   task automatic check_texel(rsp_type got);
      rsp_type want;
      if (texel_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected pixel: addr=%0d face=%0d offset=%0d last=%0d",
                     got.frame_address, got.texture_face, got.texture_offset,
                     got.last_in_column);
         return;
      end
      want = texel_q.pop_front();
      pixels_checked++;
      if (got.frame_address !== want.frame_address ||
          got.texture_face !== want.texture_face ||
          got.texture_offset !== want.texture_offset ||
          got.last_in_column !== want.last_in_column) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("pixel %0d: expected addr=%0d face=%0d offset=%0d last=%0d",
                     pixels_checked, want.frame_address, want.texture_face,
                     want.texture_offset, want.last_in_column);
            $display("pixel %0d: got      addr=%0d face=%0d offset=%0d last=%0d",
                     pixels_checked, got.frame_address, got.texture_face,
                     got.texture_offset, got.last_in_column);
         end
      end
   endtask

   // transaction monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      pin_entry_type pin;
      rsp_type       r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pin = pin_q.pop_front();
            if (req_data.command == CMD_BEGIN) begin
               load_column(req_data);
               begins_seen++;
               work_done++;
            end else if (next_pixel(r)) begin
               texel_q.push_back(pin.on ? pin.known : r);
               work_done++;
            end
         end
         if (rsp_valid && !rsp_stall)
            check_texel(rsp_data);
      end
   end

   // receiver side
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 19);
         end
      end
   end

   task automatic send(req_type t, bit on = 1'b0, rsp_type known = '0);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pin_q.push_back({on, known});
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   function automatic req_type mk_begin(int col, int h, int bot, int top, int f, int tc);
      req_type t;
      t = '0;
      t.command      = CMD_BEGIN;
      t.column       = 10'(col);
      t.wall_height  = 16'(h);
      t.span_bottom  = 9'(bot);
      t.span_top     = 9'(top);
      t.face         = 3'(f);
      t.texel_column = 6'(tc);
      return t;
   endfunction

   function automatic req_type mk_pixel();
      req_type     t;
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      t = noise[$bits(req_type)-1:0];
      t.command = CMD_PIXEL;
      return t;
   endfunction

   function automatic void add_row(req_type t, bit on = 1'b0, rsp_type known = '0);
      plan.push_back({t, on, known});
   endfunction

   task automatic send_column(bit spoiled);
      req_type     t;
      logic [63:0] noise;
      int          bot, len, cap, n, r;
      noise = {$urandom, $urandom};
      t = noise[$bits(req_type)-1:0];
      t.command = CMD_BEGIN;
      len = 2;
      if (spoiled) begin
         case ($urandom_range(2))
            0: t.wall_height = '0;
            1: t.span_top = 9'($urandom_range(0, int'(t.span_bottom)));
            default: t.face = ($urandom_range(1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
         endcase
         len = $urandom_range(0, 3);
      end else begin
         bot = $urandom_range(0, 510);
         cap = 511 - bot;
         len = ($urandom_range(19) == 0) ? $urandom_range(1, cap)
                                         : $urandom_range(1, (cap < 12) ? cap : 12);
         t.column      = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                                  : 10'($urandom_range(639));
         t.wall_height = ($urandom_range(9) < 6) ? 16'($urandom_range(1, 700))
                                                 : 16'($urandom_range(1, 65535));
         t.span_bottom = 9'(bot);
         t.span_top    = 9'(bot + len);
         t.face        = 3'($urandom_range(int'(FACE_NORTH), int'(FACE_WEST)));
      end
      send(t);
      r = $urandom_range(9);
      n = (r == 0) ? $urandom_range(0, (len > 0) ? len - 1 : 0)
                   : (r == 1) ? len + $urandom_range(1, 3) : len;
      repeat (n)
         send(mk_pixel());
   endtask

   initial begin
      int      iter;
      req_type z;
      z = '0;
      z.command = CMD_PIXEL;

      add_row(z);
      add_row(mk_begin(0, 64, 0, 1, 1, 0));
      add_row(z, 1'b1, {19'd0, 2'd0, 12'd0, 1'b1});
      add_row(z);
      add_row(mk_begin(639, 1, 479, 480, 4, 63));
      add_row(z, 1'b1, {19'd307199, 2'd3, 12'd4095, 1'b1});
      add_row(mk_begin(5, 0, 0, 10, 2, 1));
      add_row(z);
      add_row(mk_begin(6, 100, 100, 100, 3, 2));
      add_row(z);
      add_row(mk_begin(7, 100, 200, 100, 3, 2));
      add_row(z);
      add_row(mk_begin(8, 100, 10, 20, 0, 2));
      add_row(z);
      add_row(mk_begin(1023, 65535, 511, 511, 7, 63));
      add_row(req_type'('1));
      add_row(mk_begin(1023, 65535, 480, 483, 2, 33));
      add_row(z);
      add_row(z);
      add_row(z);
      add_row(mk_begin(320, 300, 100, 104, 3, 10));
      add_row(z);
      add_row(mk_begin(321, 480, 0, 2, 1, 5));
      add_row(z);
      add_row(z);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         send(plan[i].item, plan[i].on, plan[i].known);

      // long receiver hold-off while pixels keep coming
      send(mk_begin(200, 200, 140, 240, 2, 7));
      hold_req = 1'b1;
      repeat (100)
         send(mk_pixel());

      iter = 0;
      while (work_done < ITEM_TARGET) begin
         calm = (iter >= 30 && iter < 55);
         r_pick: begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 75)
               send_column(1'b0);
            else if (pick < 88)
               send_column(1'b1);
            else begin
               logic [63:0] noise;
               noise = {$urandom, $urandom};
               send(req_type'(noise[$bits(req_type)-1:0]));
            end
         end
         iter++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (texel_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d column setups, %0d pixel results checked, %0d leftover, %0d mismatches",
               begins_seen, pixels_checked, texel_q.size(), mismatches);
      $display("covered rejected begins, saturated texture rows and a long output hold-off");
      if (mismatches == 0 && texel_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
src/wcm_pkg.sv
src/wcm_divider.sv
src/wcm_pixel_gen.sv
src/wall_column_texture_mapper.sv
test/wall_column_texture_mapper_test.sv
